// ===== rtl/arpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP responder package
// Shared constants, codes and the command and status types that join the
// controller and the datapath of the ARP request responder.
// ----------------------------------------------------------------------------
package arpr_pkg;

  localparam int unsigned MAX_HW_BYTES    = 6;
  localparam int unsigned MAX_PROTO_BYTES = 4;
  localparam int unsigned MAX_FRAME_BYTES = 2047;
  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned STORE_DEPTH     = HDR_BYTES + 2 * MAX_HW_BYTES + 2 * MAX_PROTO_BYTES;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH + 1);

  localparam int unsigned OPER_HI_IDX  = 6;
  localparam int unsigned OPER_LO_IDX  = 7;
  localparam logic [7:0]  OPER_HI_BYTE = 8'h00;
  localparam logic [7:0]  OPER_LO_BYTE = 8'h02;

  typedef enum logic [2:0] {
    OUT_REPLY    = 3'd0,
    OUT_MISMATCH = 3'd1,
    OUT_TRUNC    = 3'd2,
    OUT_NOT_OURS = 3'd3,
    OUT_TOO_BIG  = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    CFG_HW_ADDR    = 3'd0,
    CFG_PROTO_ADDR = 3'd1,
    CFG_HW_LEN     = 3'd2,
    CFG_PROTO_LEN  = 3'd3,
    CFG_CAPACITY   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_CMP,
    ST_STATUS,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic     rx_en;
    logic     cnt_clr;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_cmp;
    logic     emit_status;
    logic     emit_reply;
    outcome_e code;
  } arpr_cmd_t;

  typedef struct packed {
    logic short_frame;
    logic size_bad;
    logic claim_bad;
    logic cap_bad;
    logic pr_zero;
    logic cmp_match;
    logic cmp_last;
    logic reply_last;
    logic out_free;
  } arpr_stat_t;

  // Byte j of a big-endian address of len bytes held in the low bytes of v.
  function automatic logic [7:0] addr_byte(logic [63:0] v, logic [2:0] len, logic [4:0] j);
    logic [5:0] k;
    k = {3'b000, len} - 6'd1 - {1'b0, j};
    if (k[5]) begin
      return 8'h00;
    end
    return v[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/arpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP responder controller
// Sequences reception, the frame checks, the target address compare and the
// emission of either one status result or the reply bytes.
// ----------------------------------------------------------------------------
module arpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  arpr_pkg::arpr_stat_t stat_i,
  output arpr_pkg::arpr_cmd_t  cmd_o
);

  arpr_pkg::state_e   state_q, state_d;
  arpr_pkg::outcome_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpr_pkg::ST_RX;
      code_q  <= arpr_pkg::OUT_REPLY;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.code = code_q;
    case (state_q)
      arpr_pkg::ST_RX: begin
        cmd_o.rx_en = 1'b1;
        if (in_valid_i && in_last_i) begin
          state_d = arpr_pkg::ST_CHECK;
        end
      end
      arpr_pkg::ST_CHECK: begin
        if (stat_i.short_frame) begin
          code_d  = arpr_pkg::OUT_TRUNC;
          state_d = arpr_pkg::ST_STATUS;
        end else if (stat_i.size_bad) begin
          code_d  = arpr_pkg::OUT_MISMATCH;
          state_d = arpr_pkg::ST_STATUS;
        end else if (stat_i.claim_bad) begin
          code_d  = arpr_pkg::OUT_TRUNC;
          state_d = arpr_pkg::ST_STATUS;
        end else if (!stat_i.pr_zero) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = arpr_pkg::ST_CMP;
        end else if (stat_i.cap_bad) begin
          code_d  = arpr_pkg::OUT_TOO_BIG;
          state_d = arpr_pkg::ST_STATUS;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = arpr_pkg::ST_REPLY;
        end
      end
      arpr_pkg::ST_CMP: begin
        if (!stat_i.cmp_match) begin
          code_d  = arpr_pkg::OUT_NOT_OURS;
          state_d = arpr_pkg::ST_STATUS;
        end else if (!stat_i.cmp_last) begin
          cmd_o.idx_inc = 1'b1;
        end else if (stat_i.cap_bad) begin
          code_d  = arpr_pkg::OUT_TOO_BIG;
          state_d = arpr_pkg::ST_STATUS;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = arpr_pkg::ST_REPLY;
        end
      end
      arpr_pkg::ST_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.cnt_clr     = 1'b1;
          state_d           = arpr_pkg::ST_RX;
        end
      end
      arpr_pkg::ST_REPLY: begin
        if (stat_i.out_free) begin
          cmd_o.emit_reply = 1'b1;
          if (stat_i.reply_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = arpr_pkg::ST_RX;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_d = arpr_pkg::ST_RX;
      end
    endcase
    cmd_o.rd_cmp = (state_d == arpr_pkg::ST_CMP);
  end

endmodule

// ===== rtl/arpr_datapath.sv =====
// ----------------------------------------------------------------------------
// ARP responder datapath
// Holds the configuration registers, the packet store, the byte counter, the
// check logic and the output register.
// ----------------------------------------------------------------------------
module arpr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [47:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           out_outcome_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_final_o,
  output logic [4:0]           out_length_o,
  input  arpr_pkg::arpr_cmd_t  cmd_i,
  output arpr_pkg::arpr_stat_t stat_o
);

  localparam int unsigned AW = arpr_pkg::ADDR_W;
  localparam int unsigned CW = arpr_pkg::CNT_W;

  logic [47:0]   own_hw_q;
  logic [31:0]   own_proto_q;
  logic [2:0]    own_hw_len_q;
  logic [2:0]    own_proto_len_q;
  logic [CW-1:0] cap_q;

  logic [7:0]    mem [arpr_pkg::STORE_DEPTH];
  logic [CW-1:0] cnt_q;
  logic [7:0]    hw_q, pr_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [7:0]    rdata_q;

  logic          out_valid_q;
  logic [2:0]    out_outcome_q;
  logic [7:0]    out_byte_q;
  logic          out_final_q;
  logic [4:0]    out_length_q;

  logic          in_fire;
  logic [9:0]    claimed_w;
  logic [AW-1:0] hw_a, pr_a, tp_a, send_end_a, claimed_a, rd_addr;
  logic [7:0]    reply_byte;
  logic          out_free;

  assign in_fire = in_valid_i && cmd_i.rx_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_hw_q        <= '0;
      own_proto_q     <= '0;
      own_hw_len_q    <= 3'(arpr_pkg::MAX_HW_BYTES);
      own_proto_len_q <= 3'(arpr_pkg::MAX_PROTO_BYTES);
      cap_q           <= CW'(arpr_pkg::MAX_FRAME_BYTES);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        arpr_pkg::CFG_HW_ADDR:    own_hw_q        <= cfg_data_i;
        arpr_pkg::CFG_PROTO_ADDR: own_proto_q     <= cfg_data_i[31:0];
        arpr_pkg::CFG_HW_LEN:     own_hw_len_q    <= cfg_data_i[2:0];
        arpr_pkg::CFG_PROTO_LEN:  own_proto_len_q <= cfg_data_i[2:0];
        arpr_pkg::CFG_CAPACITY:   cap_q           <= cfg_data_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (in_fire && (cnt_q < CW'(arpr_pkg::MAX_FRAME_BYTES))) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (cnt_q < CW'(arpr_pkg::STORE_DEPTH)) begin
        mem[cnt_q[AW-1:0]] <= in_byte_i;
      end
      if (cnt_q == CW'(4)) begin
        hw_q <= in_byte_i;
      end
      if (cnt_q == CW'(5)) begin
        pr_q <= in_byte_i;
      end
    end
    if (rd_addr < AW'(arpr_pkg::STORE_DEPTH)) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  assign claimed_w  = 10'(arpr_pkg::HDR_BYTES) + {1'b0, hw_q, 1'b0} + {1'b0, pr_q, 1'b0};
  assign hw_a       = hw_q[AW-1:0];
  assign pr_a       = pr_q[AW-1:0];
  assign claimed_a  = claimed_w[AW-1:0];
  assign tp_a       = AW'(arpr_pkg::HDR_BYTES) + {hw_a[AW-2:0], 1'b0} + pr_a;
  assign send_end_a = AW'(arpr_pkg::HDR_BYTES) + hw_a + pr_a;

  always_comb begin
    if (cmd_i.rd_cmp) begin
      rd_addr = tp_a + idx_d;
    end else if (idx_d < send_end_a) begin
      rd_addr = idx_d;
    end else begin
      rd_addr = idx_d - hw_a - pr_a;
    end
  end

  always_comb begin
    if (idx_q < AW'(arpr_pkg::HDR_BYTES)) begin
      if (idx_q == AW'(arpr_pkg::OPER_HI_IDX)) begin
        reply_byte = arpr_pkg::OPER_HI_BYTE;
      end else if (idx_q == AW'(arpr_pkg::OPER_LO_IDX)) begin
        reply_byte = arpr_pkg::OPER_LO_BYTE;
      end else begin
        reply_byte = rdata_q;
      end
    end else if (idx_q < AW'(arpr_pkg::HDR_BYTES) + hw_a) begin
      reply_byte = arpr_pkg::addr_byte({16'h0000, own_hw_q}, own_hw_len_q,
                                       5'(idx_q - AW'(arpr_pkg::HDR_BYTES)));
    end else if (idx_q < send_end_a) begin
      reply_byte = arpr_pkg::addr_byte({32'h0, own_proto_q}, own_proto_len_q,
                                       5'(idx_q - AW'(arpr_pkg::HDR_BYTES) - hw_a));
    end else begin
      reply_byte = rdata_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.short_frame = cnt_q < CW'(arpr_pkg::HDR_BYTES);
    stat_o.size_bad    = (pr_q != {5'b00000, own_proto_len_q}) ||
                         (pr_q > 8'(arpr_pkg::MAX_PROTO_BYTES)) ||
                         (hw_q > {5'b00000, own_hw_len_q}) ||
                         (hw_q > 8'(arpr_pkg::MAX_HW_BYTES));
    stat_o.claim_bad   = {2'b00, claimed_w} > {1'b0, cnt_q};
    stat_o.cap_bad     = cnt_q > cap_q;
    stat_o.pr_zero     = (pr_q == 8'h00);
    stat_o.cmp_match   = rdata_q == arpr_pkg::addr_byte({32'h0, own_proto_q},
                                                        own_proto_len_q, 5'(idx_q));
    stat_o.cmp_last    = (idx_q == pr_a - AW'(1));
    stat_o.reply_last  = (idx_q == claimed_a - AW'(1));
    stat_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_reply) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_outcome_q <= cmd_i.code;
      out_byte_q    <= 8'h00;
      out_final_q   <= 1'b1;
      out_length_q  <= 5'd0;
    end else if (cmd_i.emit_reply) begin
      out_outcome_q <= arpr_pkg::OUT_REPLY;
      out_byte_q    <= reply_byte;
      out_final_q   <= stat_o.reply_last;
      out_length_q  <= 5'(claimed_a);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_outcome_o = out_outcome_q;
  assign out_byte_o    = out_byte_q;
  assign out_final_o   = out_final_q;
  assign out_length_o  = out_length_q;

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_status || cmd_i.emit_reply) |-> out_free)
    else $error("result emitted while the output register is occupied");

  a_emit_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_status && cmd_i.emit_reply))
    else $error("status and reply emitted in the same cycle");

  a_reply_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_reply |-> (idx_q < claimed_a))
    else $error("reply index beyond the claimed length");

  a_count_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(arpr_pkg::MAX_FRAME_BYTES))
    else $error("byte count beyond the frame limit");

endmodule

// ===== rtl/arp_request_responder_core.sv =====
// ----------------------------------------------------------------------------
// ARP request responder
// Receives an ARP packet byte by byte, checks it and answers with a reply
// packet or a single status result.
// ----------------------------------------------------------------------------
// Packet bytes enter on the s_axis channel, one per cycle, with tlast on the
// final byte. The first 28 bytes are kept in a small packet memory and the
// frame length is counted, saturating at 2047.
// After the last byte the block stops accepting input. The header checks are
// evaluated, then the target protocol address is compared one byte per cycle,
// because each byte is fetched from the single read port of the packet memory.
// The result is then loaded into the output register: either one status
// transaction or the reply, one byte per cycle while m_axis_tready stays high,
// tlast on the final one. The block accepts the next packet in the cycle after
// its last result is loaded. When the receiver stalls the output register
// holds its transaction and the sequencer waits. Reset clears the counter, the
// sequencer and the output valid, and returns the configuration to its
// defaults; the packet memory needs no clearing. Configuration writes are
// always accepted.
// ----------------------------------------------------------------------------
module arp_request_responder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // packet_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // reply_byte [7:0], reply_length [12:8], zeros
  output logic [2:0]  m_axis_tuser,   // outcome
  output logic        m_axis_tlast    // final_result
);

  arpr_pkg::arpr_cmd_t  cmd;
  arpr_pkg::arpr_stat_t stat;
  logic [7:0]           out_byte;
  logic [4:0]           out_length;

  arpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_byte_i     (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_outcome_o (m_axis_tuser),
    .out_byte_o    (out_byte),
    .out_final_o   (m_axis_tlast),
    .out_length_o  (out_length),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.rx_en;
  assign m_axis_tdata  = {3'b000, out_length, out_byte};

endmodule
